### rtl/core/pcs_pkg.sv
// Shared types and constants for the pitch change segmenter.
package pcs_pkg;

  localparam int PITCH_W         = 15;
  localparam int FRAME_W         = 16;
  localparam int THR_W           = 15;
  localparam int HALF_WINDOW_DEF = 6;
  localparam int MAX_FRAMES_DEF  = 65536;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

  typedef struct packed {
    logic [PITCH_W-1:0] pitch_in;
    logic               seg_last;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] boundary_frame;
    logic [PITCH_W-1:0] note_pitch;
  } out_item_t;

endpackage

### rtl/core/pcs_front.sv
// Front end: takes pitch frames, slides the window and queues frames to evaluate.
module pcs_front
  import pcs_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
  localparam int WIN_LEN    = 2 * HALF_WINDOW,
  localparam int ENTRY_W    = WIN_LEN * PITCH_W + FRAME_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_data,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_entry,
  input  logic               q_full
);

  localparam logic [FRAME_W-1:0] FC_MAX  = FRAME_W'(MAX_FRAMES - 1);
  localparam logic [FRAME_W-1:0] EVAL_N  = FRAME_W'(WIN_LEN - 1);
  localparam logic [FRAME_W-1:0] CTR_OFS = FRAME_W'(HALF_WINDOW - 1);

  logic [WIN_LEN-1:0][PITCH_W-1:0] window;
  logic [WIN_LEN-1:0][PITCH_W-1:0] win_sh;
  logic [FRAME_W-1:0]              frame_count;
  logic [FRAME_W-1:0]              centre;
  logic                            accept;
  logic                            evaluate;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign evaluate = frame_count >= EVAL_N;
  assign centre   = frame_count - CTR_OFS;

  // oldest frame at index 0
  always_comb begin
    for (int k = 0; k < WIN_LEN - 1; k++) begin
      win_sh[k] = window[k+1];
    end
    win_sh[WIN_LEN-1] = in_data.pitch_in;
  end

  assign q_push  = accept && (in_data.seg_last || evaluate);
  assign q_entry = {in_data.seg_last, centre, win_sh};

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      frame_count <= '0;
    end else if (accept) begin
      if (in_data.seg_last) begin
        window      <= '0;
        frame_count <= '0;
      end else begin
        window <= win_sh;
        if (frame_count < FC_MAX) begin
          frame_count <= frame_count + FRAME_W'(1);
        end
      end
    end
  end

endmodule

### rtl/core/pcs_queue.sv
// Short FIFO between the front end and the median engine.
module pcs_queue
  import pcs_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = count == CW'(DEPTH);
  assign q_empty = count == '0;
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/pcs_back.sv
// Back end: windowed median by rank search, note tracking and boundary output.
module pcs_back
  import pcs_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF,
  localparam int WIN_LEN    = 2 * HALF_WINDOW,
  localparam int ENTRY_W    = WIN_LEN * PITCH_W + FRAME_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr,
  input  logic [THR_W-1:0]   cfg_data,
  input  logic [ENTRY_W-1:0] q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_data
);

  localparam int IW = $clog2(WIN_LEN);
  localparam int CW = $clog2(WIN_LEN + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(WIN_LEN - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0]                      state;
  logic [IW-1:0]                   idx;
  logic [WIN_LEN-1:0][PITCH_W-1:0] win;
  logic [WIN_LEN-1:0]              mask;
  logic [CW-1:0]                   rank;
  logic [FRAME_W-1:0]              centre;
  logic [PITCH_W-1:0]              med;
  logic [PITCH_W-1:0]              last_note;
  logic [FRAME_W-1:0]              last_boundary;
  logic [THR_W-1:0]                thr;
  logic                            out_valid;

  logic [WIN_LEN-1:0][PITCH_W-1:0] e_win;
  logic [FRAME_W-1:0]              e_centre;
  logic                            e_last;
  logic [WIN_LEN-1:0]              e_pos;
  logic [WIN_LEN-1:0]              e_mask;
  logic [CW-1:0]                   e_cnt;
  logic [PITCH_W-1:0]              cand;
  logic [CW-1:0]                   lt_cnt;
  logic [CW-1:0]                   le_cnt;
  logic                            hit;
  logic [PITCH_W-1:0]              diff;
  logic [FRAME_W:0]                bound_lim;
  logic                            out_free;
  logic                            out_set;

  assign {e_last, e_centre, e_win} = q_data;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // positive values, less the newest of them
  always_comb begin
    e_cnt = '0;
    for (int k = 0; k < WIN_LEN; k++) begin
      e_pos[k] = e_win[k] != '0;
    end
    for (int k = 0; k < WIN_LEN; k++) begin
      e_mask[k] = e_pos[k] && ((e_pos >> (k + 1)) != '0);
      e_cnt     = e_cnt + CW'(e_mask[k]);
    end
  end

  // candidate at idx is the median if its rank range covers the target rank
  always_comb begin
    cand   = win[idx];
    lt_cnt = '0;
    le_cnt = '0;
    for (int k = 0; k < WIN_LEN; k++) begin
      lt_cnt = lt_cnt + CW'(mask[k] && (win[k] < cand));
      le_cnt = le_cnt + CW'(mask[k] && (win[k] <= cand));
    end
    hit = mask[idx] && (lt_cnt <= rank) && (rank < le_cnt);
  end

  assign diff      = (med > last_note) ? (med - last_note) : (last_note - med);
  assign bound_lim = {1'b0, last_boundary} + (FRAME_W + 1)'(HALF_WINDOW);
  assign out_set   = (state == ST_DECIDE) && out_free && (diff > thr) &&
                     ({1'b0, centre} > bound_lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      win    <= e_win;
      mask   <= e_mask;
      rank   <= e_cnt >> 1;
      centre <= e_centre;
    end
    if (state == ST_DECIDE && out_free) begin
      out_data.boundary_frame <= centre;
      out_data.note_pitch     <= med;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      idx           <= '0;
      med           <= '0;
      last_note     <= '0;
      last_boundary <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (e_last) begin
              // end of segment: start the next one from scratch
              last_note     <= '0;
              last_boundary <= '0;
            end else begin
              idx   <= '0;
              med   <= '0;
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (hit) begin
            med <= cand;
          end
          if (idx == IDX_LAST) begin
            state <= ST_DECIDE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        ST_DECIDE: begin
          // hold until the output slot is free
          if (out_free) begin
            if (diff > thr) begin
              last_note <= med;
              if ({1'b0, centre} > bound_lim) begin
                last_boundary <= centre;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/pitch_change_segmenter_core.sv
// An evaluated frame goes through the queue, the back end's rank search and its decide state.
// The back end takes a new evaluated frame only in its idle state; its rank search checks
//   one window candidate per cycle, and a two-entry queue absorbs bursts.
// Frames that only fill the window are not queued; a final frame is queued and ends the segment.
// Reset (rst, synchronous): clears window, counters, note state and the queue; threshold to 128.
// Top level of the pitch change segmenter.
module pitch_change_segmenter_core
  import pcs_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF,
  parameter int MAX_FRAMES  = MAX_FRAMES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  in_item_t         in_data,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_data,
  input  logic             cfg_wr,
  input  logic [THR_W-1:0] cfg_data
);

  localparam int WIN_LEN = 2 * HALF_WINDOW;
  localparam int ENTRY_W = WIN_LEN * PITCH_W + FRAME_W + 1;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_wdata;
  logic [ENTRY_W-1:0] q_rdata;

  pcs_front #(
    .HALF_WINDOW(HALF_WINDOW),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_push (q_push),
    .q_entry(q_wdata),
    .q_full (q_full)
  );

  pcs_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_data(q_wdata),
    .q_full (q_full),
    .rd     (q_pop),
    .rd_data(q_rdata),
    .q_empty(q_empty)
  );

  pcs_back #(
    .HALF_WINDOW(HALF_WINDOW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg_wr  (cfg_wr),
    .cfg_data(cfg_data),
    .q_data  (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

endmodule

### rtl/core/pcs_checker.sv
// Port-level checks for the pitch change segmenter, bound to the top level.
module pcs_checker
  import pcs_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
  input logic      clk,
  input logic      rst,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_data
);

  // no result or backpressure survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full flag present after reset");

  // a boundary always lies past the first half window
  a_boundary_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_data.boundary_frame > FRAME_W'(HALF_WINDOW)))
    else $error("boundary frame inside first half window");

  // a waiting result stays put until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

  // a waiting result carries a fully known pitch
  a_pitch_width: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !$isunknown(out_data.note_pitch))
    else $error("note pitch unknown on a waiting result");

endmodule

bind pitch_change_segmenter_core pcs_checker #(
  .HALF_WINDOW(HALF_WINDOW)
) u_pcs_checker (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);
